// File: hw/rtl/mcrb_pkg.sv
`timescale 1ns / 1ps

package mcrb_pkg;

    localparam int RING_DEPTH   = 1024;
    localparam int PTR_W        = $clog2(RING_DEPTH);
    localparam int NUM_LANES    = 4;
    localparam int LANE_W       = $clog2(NUM_LANES + 1);
    localparam int MAX_BLOCK    = 64;
    localparam int LEN_W        = 7;
    localparam int SAMPLE_W     = 64;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 10;
    localparam int CHAN_W       = 3;

    localparam logic [CFG_DATA_W-1:0] CAP_RESET  = CFG_DATA_W'(1023);
    localparam logic [CHAN_W-1:0]     CHAN_RESET = CHAN_W'(2);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPACITY = 1'b0,
        CFG_CHANNELS = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_PUSH_OK   = 2'd0,
        ST_PUSH_DROP = 2'd1,
        ST_PULL_DATA = 2'd2,
        ST_PULL_DENY = 2'd3
    } t_status;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_PULL = 1'b1;

    typedef logic [NUM_LANES-1:0][SAMPLE_W-1:0] t_frame;

    // Step a ring pointer by one slot with wrap.
    function automatic logic [PTR_W-1:0] ptr_advance(
        input logic [PTR_W-1:0] p,
        input logic [PTR_W:0]   slots
    );
        logic [PTR_W:0] nxt;
        nxt = {1'b0, p} + (PTR_W+1)'(1);
        return (nxt >= slots) ? '0 : nxt[PTR_W-1:0];
    endfunction

    // Frames between the read and write pointers.
    function automatic logic [PTR_W-1:0] ready_count(
        input logic [PTR_W-1:0] wp,
        input logic [PTR_W-1:0] rp,
        input logic [PTR_W:0]   slots
    );
        logic [PTR_W:0] diff;
        if (wp >= rp) begin
            diff = {1'b0, wp} - {1'b0, rp};
        end else begin
            diff = {1'b0, wp} + slots - {1'b0, rp};
        end
        return diff[PTR_W-1:0];
    endfunction

endpackage

// File: hw/rtl/multichannel_block_ring_buffer_top.sv
`timescale 1ns / 1ps

// Channel   Handshake                    Payload
// input     i_in_valid / o_in_ready      i_cmd, i_block_length, i_block_start, i_sample_ch0..3
// result    o_out_valid / i_out_ready    o_status, o_last, o_out_ch0..3, o_frames_ready
// config    i_cfg_we                     i_cfg_index, i_cfg_data
//
// A push gives one result; pushes stream at one per cycle while results are taken.
// An accepted pull of N frames reads the frame memory once per frame through a
// registered read port, and takes no new transaction until its last frame is loaded.
// Result stalls stall the memory reads; a refused pull gives a single deny result.
// Reset is synchronous; the frame memory is not cleared and holds old data.
module multichannel_block_ring_buffer_top import mcrb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_cmd,
    input  logic [LEN_W-1:0]      i_block_length,
    input  logic                  i_block_start,
    input  logic [SAMPLE_W-1:0]   i_sample_ch0,
    input  logic [SAMPLE_W-1:0]   i_sample_ch1,
    input  logic [SAMPLE_W-1:0]   i_sample_ch2,
    input  logic [SAMPLE_W-1:0]   i_sample_ch3,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_status,
    output logic                  o_last,
    output logic [SAMPLE_W-1:0]   o_out_ch0,
    output logic [SAMPLE_W-1:0]   o_out_ch1,
    output logic [SAMPLE_W-1:0]   o_out_ch2,
    output logic [SAMPLE_W-1:0]   o_out_ch3,
    output logic [PTR_W-1:0]      o_frames_ready,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic {
        S_IDLE,
        S_PULL
    } t_state;

    t_state                r_state, n_state;
    logic [CFG_DATA_W-1:0] r_cap, n_cap;
    logic [CHAN_W-1:0]     r_chan, n_chan;
    logic [PTR_W-1:0]      r_rp, n_rp;
    logic [PTR_W-1:0]      r_wp, n_wp;
    logic [PTR_W-1:0]      r_stg, n_stg;
    logic [LEN_W-1:0]      r_fl, n_fl;
    logic                  r_acc, n_acc;

    logic [PTR_W-1:0]      r_issue_addr, n_issue_addr;
    logic [LEN_W-1:0]      r_issue_left, n_issue_left;
    logic                  r_rd_valid, n_rd_valid;
    logic                  r_rd_last, n_rd_last;
    t_frame                r_rd_data;
    logic [PTR_W-1:0]      r_pull_ready, n_pull_ready;

    logic                  r_out_valid, n_out_valid;
    t_status               r_status, n_status;
    logic                  r_last, n_last;
    t_frame                r_ch, n_ch;
    logic [PTR_W-1:0]      r_ready, n_ready;

    t_frame                mem [RING_DEPTH];

    logic [PTR_W-1:0]      cap_eff;
    logic [PTR_W:0]        slots;
    logic [LANE_W-1:0]     lanes;
    logic [NUM_LANES-1:0]  lane_en;
    logic [LEN_W-1:0]      len_eff;
    t_frame                in_frame;

    logic                  out_load;
    logic                  in_fire;
    logic                  rd_adv;
    logic                  issue;

    logic [PTR_W-1:0]      ready_now;
    logic [PTR_W-1:0]      free_slots;
    logic                  take;
    logic                  acc_e;
    logic [PTR_W-1:0]      stg_e;
    logic [LEN_W-1:0]      fl_e;
    logic [PTR_W-1:0]      stg_nx;
    logic [LEN_W-1:0]      fl_nx;
    logic                  commit;
    logic [PTR_W-1:0]      wp_nx;
    logic [PTR_W-1:0]      ready_after_push;
    logic                  mem_we;

    logic                  pull_ok;
    logic [PTR_W:0]        rp_sum;
    logic [PTR_W-1:0]      rp_nx;
    logic [PTR_W-1:0]      ready_after_pull;

    // Effective configuration: zero acts as one, channel count saturates.
    assign cap_eff = (r_cap == '0) ? PTR_W'(1) : r_cap;
    assign slots   = {1'b0, cap_eff} + (PTR_W+1)'(1);
    assign lanes   = (r_chan == '0) ? LANE_W'(1) :
                     (r_chan > CHAN_W'(NUM_LANES)) ? LANE_W'(NUM_LANES) : r_chan[LANE_W-1:0];

    always_comb begin
        for (int c = 0; c < NUM_LANES; c++) begin
            lane_en[c] = (LANE_W'(c) < lanes);
        end
    end

    assign len_eff = (i_block_length == '0) ? LEN_W'(1) :
                     (i_block_length > LEN_W'(MAX_BLOCK)) ? LEN_W'(MAX_BLOCK) : i_block_length;

    assign in_frame[0] = i_sample_ch0;
    assign in_frame[1] = i_sample_ch1;
    assign in_frame[2] = i_sample_ch2;
    assign in_frame[3] = i_sample_ch3;

    assign out_load   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_load;
    assign in_fire    = i_in_valid && o_in_ready;

    // Push path: block admission, staged write and commit.
    assign ready_now  = ready_count(r_wp, r_rp, slots);
    assign free_slots = cap_eff - ready_now;
    assign take       = i_block_start || (r_fl != '0);
    assign acc_e      = i_block_start ? (free_slots >= PTR_W'(len_eff)) : r_acc;
    assign stg_e      = i_block_start ? r_wp : r_stg;
    assign fl_e       = i_block_start ? len_eff : r_fl;
    assign stg_nx     = ptr_advance(stg_e, slots);
    assign fl_nx      = fl_e - LEN_W'(1);
    assign commit     = take && acc_e && (fl_nx == '0);
    assign wp_nx      = commit ? stg_nx : r_wp;
    assign ready_after_push = ready_count(wp_nx, r_rp, slots);
    assign mem_we     = in_fire && (i_cmd == CMD_PUSH) && take && acc_e;

    // Pull path. A granted pull never exceeds the ring, so one wrap suffices.
    assign pull_ok = (ready_now >= PTR_W'(len_eff));
    assign rp_sum  = {1'b0, r_rp} + (PTR_W+1)'(len_eff);
    assign rp_nx   = (rp_sum >= slots) ? PTR_W'(rp_sum - slots) : rp_sum[PTR_W-1:0];
    assign ready_after_pull = ready_count(r_wp, rp_nx, slots);

    // Read pipeline: issue a read while the read stage is free or draining.
    assign rd_adv = (r_state == S_PULL) && r_rd_valid && out_load;
    assign issue  = (r_state == S_PULL) && (r_issue_left != '0) && (!r_rd_valid || out_load);

    always_comb begin
        n_state      = r_state;
        n_cap        = r_cap;
        n_chan       = r_chan;
        n_rp         = r_rp;
        n_wp         = r_wp;
        n_stg        = r_stg;
        n_fl         = r_fl;
        n_acc        = r_acc;
        n_issue_addr = r_issue_addr;
        n_issue_left = r_issue_left;
        n_rd_valid   = r_rd_valid;
        n_rd_last    = r_rd_last;
        n_pull_ready = r_pull_ready;
        n_out_valid  = r_out_valid;
        n_status     = r_status;
        n_last       = r_last;
        n_ch         = r_ch;
        n_ready      = r_ready;

        if (out_load) begin
            n_out_valid = 1'b0;
        end

        if (in_fire) begin
            n_out_valid = 1'b1;
            n_last      = 1'b1;
            n_ch        = '0;
            if (i_cmd == CMD_PUSH) begin
                n_status = ST_PUSH_DROP;
                if (take) begin
                    n_stg = stg_e;
                    n_acc = acc_e;
                    n_fl  = fl_nx;
                    if (acc_e) begin
                        n_stg    = stg_nx;
                        n_status = ST_PUSH_OK;
                    end
                    if (commit) begin
                        n_wp  = wp_nx;
                        n_acc = 1'b0;
                    end
                end
                n_ready = ready_after_push;
            end else if (!pull_ok) begin
                n_status = ST_PULL_DENY;
                n_ready  = ready_now;
            end else begin
                // The read pointer moves at once; frames follow from memory.
                n_out_valid  = 1'b0;
                n_rp         = rp_nx;
                n_pull_ready = ready_after_pull;
                n_issue_addr = r_rp;
                n_issue_left = len_eff;
                n_state      = S_PULL;
            end
        end

        if (rd_adv) begin
            n_out_valid = 1'b1;
            n_status    = ST_PULL_DATA;
            n_last      = r_rd_last;
            n_ready     = r_pull_ready;
            for (int c = 0; c < NUM_LANES; c++) begin
                n_ch[c] = lane_en[c] ? r_rd_data[c] : '0;
            end
            n_rd_valid = 1'b0;
            if (r_issue_left == '0) begin
                n_state = S_IDLE;
            end
        end

        if (issue) begin
            n_rd_valid   = 1'b1;
            n_rd_last    = (r_issue_left == LEN_W'(1));
            n_issue_addr = ptr_advance(r_issue_addr, slots);
            n_issue_left = r_issue_left - LEN_W'(1);
        end

        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CAPACITY: begin
                    n_cap = i_cfg_data;
                    n_rp  = '0;
                    n_wp  = '0;
                    n_stg = '0;
                    n_fl  = '0;
                    n_acc = 1'b0;
                end
                CFG_CHANNELS: begin
                    n_chan = i_cfg_data[CHAN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_issue_addr <= n_issue_addr;
        r_rd_last    <= n_rd_last;
        r_pull_ready <= n_pull_ready;
        r_status     <= n_status;
        r_last       <= n_last;
        r_ch         <= n_ch;
        r_ready      <= n_ready;
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cap        <= CAP_RESET;
            r_chan       <= CHAN_RESET;
            r_rp         <= '0;
            r_wp         <= '0;
            r_stg        <= '0;
            r_fl         <= '0;
            r_acc        <= 1'b0;
            r_issue_left <= '0;
            r_rd_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cap        <= n_cap;
            r_chan       <= n_chan;
            r_rp         <= n_rp;
            r_wp         <= n_wp;
            r_stg        <= n_stg;
            r_fl         <= n_fl;
            r_acc        <= n_acc;
            r_issue_left <= n_issue_left;
            r_rd_valid   <= n_rd_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Frame memory with a write mask per lane; pushes and pull reads never overlap.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            for (int c = 0; c < NUM_LANES; c++) begin
                if (lane_en[c]) begin
                    mem[stg_e][c] <= in_frame[c];
                end
            end
        end
        if (issue) begin
            r_rd_data <= mem[r_issue_addr];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_last         = r_last;
    assign o_out_ch0      = r_ch[0];
    assign o_out_ch1      = r_ch[1];
    assign o_out_ch2      = r_ch[2];
    assign o_out_ch3      = r_ch[3];
    assign o_frames_ready = r_ready;

`ifndef SYNTHESIS
    a_idle_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_rd_valid)
        else $error("read stage busy while idle");

    a_ready_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ready_now <= cap_eff)
        else $error("ready frames exceed capacity");

    a_open_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc |-> r_fl != '0)
        else $error("accepted block without frames left");

    a_last_ends_pull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_adv && r_rd_last |=> r_state == S_IDLE && o_out_valid && o_last)
        else $error("pull did not end on its last frame");

    a_issue_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |-> {1'b0, r_issue_addr} < slots)
        else $error("read address outside ring");
`endif

endmodule

// File: bench/multichannel_block_ring_buffer_top_tb.sv
`timescale 1ns / 1ps

module multichannel_block_ring_buffer_top_tb;
    import mcrb_pkg::*;

    localparam int unsigned RUN_LIMIT = 500000;

    typedef struct packed {
        logic             cmd;
        logic [LEN_W-1:0] len;
        logic             start;
        t_frame           samples;
    } ring_request_t;

    typedef struct packed {
        t_status          status;
        logic             last;
        t_frame           lanes;
        logic [PTR_W-1:0] ready;
    } frame_result_t;

    class ring_buffer_scoreboard;
        logic [SAMPLE_W-1:0] frame_mem [NUM_LANES][RING_DEPTH];
        int unsigned rd_ptr, wr_ptr, staged_ptr, frames_left;
        bit          block_ok;
        int unsigned capacity_reg, channels_reg;
        frame_result_t expected_frames[$];
        int errors, n_in, n_checked, n_push_refused, n_pull_refused, n_frames_out;

        function new();
            capacity_reg = CAP_RESET;
            channels_reg = CHAN_RESET;
            clear_pointers();
        endfunction

        function void clear_pointers();
            rd_ptr = 0;
            wr_ptr = 0;
            staged_ptr = 0;
            frames_left = 0;
            block_ok = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_CAPACITY) begin
                capacity_reg = data;
                clear_pointers();
            end else begin
                channels_reg = data[CHAN_W-1:0];
            end
        endfunction

        function int unsigned slots();
            int unsigned c;
            c = capacity_reg;
            if (c < 1) c = 1;
            if (c > RING_DEPTH - 1) c = RING_DEPTH - 1;
            return c + 1;
        endfunction

        function int unsigned lanes();
            int unsigned a;
            a = channels_reg;
            if (a < 1) a = 1;
            if (a > NUM_LANES) a = NUM_LANES;
            return a;
        endfunction

        function int unsigned ready();
            if (wr_ptr >= rd_ptr) return wr_ptr - rd_ptr;
            return wr_ptr + slots() - rd_ptr;
        endfunction

        function int unsigned step_ptr(int unsigned p, int unsigned n_slots);
            return (p + 1 >= n_slots) ? 0 : p + 1;
        endfunction

        function int unsigned clamp_len(logic [LEN_W-1:0] v);
            if (v < 1) return 1;
            if (v > MAX_BLOCK) return MAX_BLOCK;
            return v;
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction

        // Works out the results of one accepted transaction and updates the ring state.
        function void apply_request(ring_request_t req);
            int unsigned n_slots, n_lanes, len, free_slots, first, p, after;
            int i, c;
            bit take;
            frame_result_t res;
            n_slots = slots();
            n_lanes = lanes();
            len = clamp_len(req.len);
            n_in++;
            res = '0;
            res.last = 1'b1;
            if (req.cmd == CMD_PUSH) begin
                res.status = ST_PUSH_DROP;
                take = 0;
                if (req.start) begin
                    free_slots = n_slots - 1 - ready();
                    staged_ptr = wr_ptr;
                    block_ok = (free_slots >= len);
                    frames_left = len;
                    take = 1;
                end else if (frames_left != 0) begin
                    take = 1;
                end
                if (take) begin
                    if (block_ok) begin
                        for (c = 0; c < n_lanes; c++) frame_mem[c][staged_ptr] = req.samples[c];
                        staged_ptr = step_ptr(staged_ptr, n_slots);
                        res.status = ST_PUSH_OK;
                    end
                    frames_left--;
                    // The block becomes visible to readers only after its last frame.
                    if (frames_left == 0 && block_ok) begin
                        wr_ptr = staged_ptr;
                        block_ok = 0;
                    end
                end
                if (res.status == ST_PUSH_DROP) n_push_refused++;
                res.ready = ready();
                expected_frames.push_back(res);
            end else if (ready() < len) begin
                res.status = ST_PULL_DENY;
                res.ready = ready();
                n_pull_refused++;
                expected_frames.push_back(res);
            end else begin
                first = rd_ptr;
                p = first;
                for (i = 0; i < len; i++) p = step_ptr(p, n_slots);
                rd_ptr = p;
                after = ready();
                p = first;
                for (i = 0; i < len; i++) begin
                    res = '0;
                    res.status = ST_PULL_DATA;
                    res.last = (i + 1 == len);
                    for (c = 0; c < n_lanes; c++) res.lanes[c] = frame_mem[c][p];
                    res.ready = after;
                    expected_frames.push_back(res);
                    p = step_ptr(p, n_slots);
                end
                n_frames_out += len;
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 30) $display("Mismatch at result %0d: %s", n_checked, msg);
        endtask

        task check_result(frame_result_t got);
            frame_result_t exp;
            int c;
            if (expected_frames.size() == 0) begin
                report("result arrived with nothing outstanding");
                return;
            end
            exp = expected_frames.pop_front();
            if (got.status !== exp.status)
                report($sformatf("status %0d, expected %0d", got.status, exp.status));
            if (got.last !== exp.last)
                report($sformatf("last %b, expected %b", got.last, exp.last));
            for (c = 0; c < NUM_LANES; c++) begin
                if (got.lanes[c] !== exp.lanes[c])
                    report($sformatf("channel %0d 0x%h, expected 0x%h",
                                     c, got.lanes[c], exp.lanes[c]));
            end
            if (got.ready !== exp.ready)
                report($sformatf("frames_ready %0d, expected %0d", got.ready, exp.ready));
            n_checked++;
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_cmd;
    logic [LEN_W-1:0]      i_block_length;
    logic                  i_block_start;
    logic [SAMPLE_W-1:0]   i_sample_ch0;
    logic [SAMPLE_W-1:0]   i_sample_ch1;
    logic [SAMPLE_W-1:0]   i_sample_ch2;
    logic [SAMPLE_W-1:0]   i_sample_ch3;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [1:0]            o_status;
    logic                  o_last;
    logic [SAMPLE_W-1:0]   o_out_ch0;
    logic [SAMPLE_W-1:0]   o_out_ch1;
    logic [SAMPLE_W-1:0]   o_out_ch2;
    logic [SAMPLE_W-1:0]   o_out_ch3;
    logic [PTR_W-1:0]      o_frames_ready;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ring_buffer_scoreboard sb;
    int          src_idle_pct;
    int          dst_idle_pct;
    int          settings_used;
    int unsigned cycle_count;
    frame_result_t seen_result;
    bit            seen_fire;

    multichannel_block_ring_buffer_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_block_length (i_block_length),
        .i_block_start  (i_block_start),
        .i_sample_ch0   (i_sample_ch0),
        .i_sample_ch1   (i_sample_ch1),
        .i_sample_ch2   (i_sample_ch2),
        .i_sample_ch3   (i_sample_ch3),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_last         (o_last),
        .o_out_ch0      (o_out_ch0),
        .o_out_ch1      (o_out_ch1),
        .o_out_ch2      (o_out_ch2),
        .o_out_ch3      (o_out_ch3),
        .o_frames_ready (o_frames_ready),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        i_out_ready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // Results are sampled at the rising clock edge and checked at the falling edge, so the
    // transaction that caused them has always been noted by then.
    always begin
        @(posedge i_clk);
        seen_fire = (i_rst_n === 1'b1) && (o_out_valid === 1'b1) && (i_out_ready === 1'b1);
        if (seen_fire) begin
            seen_result.status = t_status'(o_status);
            seen_result.last = o_last;
            seen_result.lanes = {o_out_ch3, o_out_ch2, o_out_ch1, o_out_ch0};
            seen_result.ready = o_frames_ready;
        end
        @(negedge i_clk);
        if (seen_fire) sb.check_result(seen_result);
    end

    initial begin
        wait (cycle_count >= RUN_LIMIT);
        $display("Run stopped at the cycle limit with %0d results outstanding.", sb.pending());
        $display("FAILURE");
        $finish;
    end

    function automatic t_frame random_frame();
        t_frame f;
        int c;
        for (c = 0; c < NUM_LANES; c++) f[c] = {$urandom, $urandom};
        return f;
    endfunction

    function automatic ring_request_t make_req(logic cmd, logic [LEN_W-1:0] len,
                                               logic start, t_frame f);
        ring_request_t r;
        r.cmd = cmd;
        r.len = len;
        r.start = start;
        r.samples = f;
        return r;
    endfunction

    // Lengths of one and of the maximum sometimes use the out-of-range encodings.
    function automatic logic [LEN_W-1:0] encode_len(int unsigned n);
        if (n == 1 && $urandom_range(7) == 0) return '0;
        if (n == MAX_BLOCK && $urandom_range(3) == 0) return LEN_W'($urandom_range(127, 65));
        return LEN_W'(n);
    endfunction

    task automatic send_request(input ring_request_t req);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_cmd          <= req.cmd;
        i_block_length <= req.len;
        i_block_start  <= req.start;
        i_sample_ch0   <= req.samples[0];
        i_sample_ch1   <= req.samples[1];
        i_sample_ch2   <= req.samples[2];
        i_sample_ch3   <= req.samples[3];
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        sb.apply_request(req);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // The lane count changes first and the capacity write then empties the ring,
    // so every stored frame is always read back with the lanes it was written with.
    task automatic configure(input int unsigned cap, input int unsigned chans);
        logic [CFG_DATA_W-1:0] chan_word;
        chan_word = {7'($urandom_range(127)), 3'(chans)};
        write_reg(CFG_CHANNELS, chan_word);
        write_reg(CFG_CAPACITY, CFG_DATA_W'(cap));
        settings_used++;
    endtask

    task automatic push_block(input int unsigned n, input int unsigned stop_after);
        int unsigned k;
        send_request(make_req(CMD_PUSH, encode_len(n), 1'b1, random_frame()));
        for (k = 1; k < stop_after; k++)
            send_request(make_req(CMD_PUSH, LEN_W'($urandom_range(127)), 1'b0, random_frame()));
    endtask

    task automatic pull_block(input int unsigned n);
        send_request(make_req(CMD_PULL, encode_len(n), 1'($urandom_range(1)), random_frame()));
    endtask

    task automatic run_directed();
        t_frame ones;
        ones = '1;
        configure(3, 4);
        pull_block(1);                                              // empty ring refuses
        send_request(make_req(CMD_PUSH, 7'd5, 1'b0, ones));         // frame with no block open
        send_request(make_req(CMD_PUSH, 7'd2, 1'b1, ones));
        send_request(make_req(CMD_PUSH, 7'd0, 1'b0, '0));           // commits two frames
        send_request(make_req(CMD_PUSH, 7'd2, 1'b1, random_frame())); // too little space
        send_request(make_req(CMD_PUSH, 7'd9, 1'b0, random_frame())); // rest of dropped block
        send_request(make_req(CMD_PULL, 7'd0, 1'b0, '0));           // zero length acts as one
        send_request(make_req(CMD_PUSH, 7'd3, 1'b1, random_frame())); // dropped, left open
        send_request(make_req(CMD_PUSH, 7'd1, 1'b1, random_frame())); // restart abandons it
        send_request(make_req(CMD_PULL, 7'd2, 1'b1, ones));
        send_request(make_req(CMD_PUSH, 7'd3, 1'b1, ones));
        send_request(make_req(CMD_PUSH, 7'd3, 1'b0, random_frame()));
        send_request(make_req(CMD_PUSH, 7'd0, 1'b1, random_frame())); // abandons accepted block
        send_request(make_req(CMD_PULL, 7'd127, 1'b0, '0));         // saturates to the maximum
        send_request(make_req(CMD_PULL, 7'd1, 1'b0, ones));
        send_request(make_req(CMD_PUSH, 7'd3, 1'b1, ones));
        send_request(make_req(CMD_PUSH, 7'd0, 1'b0, '0));
        send_request(make_req(CMD_PUSH, 7'd64, 1'b0, random_frame())); // ring now full
        send_request(make_req(CMD_PUSH, 7'd1, 1'b1, random_frame())); // no space at all
        send_request(make_req(CMD_PULL, 7'd3, 1'b0, '0));
        drain();
    endtask

    task automatic run_random(input int n_items);
        int unsigned n, stop_at, rdy, free_slots, pick, hi;
        int done;
        bit paused;
        done = 0;
        paused = 0;
        while (done < n_items) begin
            if (!paused && done >= n_items / 2) begin
                drain();
                paused = 1;
            end
            rdy = sb.ready();
            free_slots = sb.slots() - 1 - rdy;
            pick = $urandom_range(99);
            if (pick < 55) begin
                if (free_slots > 0 && $urandom_range(4) != 0) begin
                    hi = (free_slots < 24) ? free_slots : 24;
                    n = $urandom_range(hi, 1);
                end else begin
                    n = $urandom_range(MAX_BLOCK, 1);
                end
                // Keep the last block of a phase within the phase's share of transactions.
                if (n > unsigned'(n_items - done)) n = unsigned'(n_items - done);
                stop_at = n;
                if ($urandom_range(9) == 0) stop_at = $urandom_range(n, 1);
                push_block(n, stop_at);
                done += stop_at;
            end else if (pick < 85) begin
                hi = (rdy < MAX_BLOCK) ? rdy : MAX_BLOCK;
                n = (hi > 0) ? $urandom_range(hi, 1) : 1;
                pull_block(n);
                done++;
            end else if (pick < 92) begin
                n = (rdy < MAX_BLOCK) ? $urandom_range(MAX_BLOCK, rdy + 1) : MAX_BLOCK;
                pull_block(n);
                done++;
            end else begin
                done++;
                send_request(make_req(CMD_PUSH, LEN_W'($urandom_range(127)), 1'b0,
                                      random_frame()));
            end
        end
        drain();
    endtask

    initial begin
        int unsigned caps [6];
        int unsigned chans [6];
        int ph;
        caps  = '{40, 1, 1023, 0, 9, 300};
        chans = '{7, 1, 3, 0, 5, 4};
        sb = new();
        cycle_count = 0;
        settings_used = 0;
        src_idle_pct = 26;
        dst_idle_pct = 58;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_cmd          <= CMD_PUSH;
        i_block_length <= '0;
        i_block_start  <= 1'b0;
        i_sample_ch0   <= '0;
        i_sample_ch1   <= '0;
        i_sample_ch2   <= '0;
        i_sample_ch3   <= '0;
        i_out_ready    <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= CFG_CAPACITY;
        i_cfg_data     <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        for (ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin
                src_idle_pct = 58;
                dst_idle_pct = 26;
            end else if (ph == 4) begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
            configure(caps[ph], chans[ph]);
            run_random(35);
        end

        drain();
        repeat (20) @(posedge i_clk);
        $display("Covered %0d transactions and %0d checked results over %0d register settings.",
                 sb.n_in, sb.n_checked, settings_used);
        $display("Refused pushes: %0d, refused pulls: %0d, frames pulled: %0d.",
                 sb.n_push_refused, sb.n_pull_refused, sb.n_frames_out);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/mcrb_pkg.sv
hw/rtl/multichannel_block_ring_buffer_top.sv
bench/multichannel_block_ring_buffer_top_tb.sv
